FILE: rtl/vertex_quarter_turn_transform_core_assert.svh
// assertion macros shared by the vertex quarter-turn transform modules
`ifndef VERTEX_QUARTER_TURN_TRANSFORM_CORE_ASSERT_SVH
`define VERTEX_QUARTER_TURN_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define VQT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vqt assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define VQT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vqt assertion failed");

`endif

FILE: rtl/vqt_pkg.sv
// types, codes and constants of the vertex quarter-turn transform
`timescale 1ns / 1ps
`default_nettype none
package vqt_pkg;

  localparam int VQT_QUEUE_DEPTH = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int POS_SUM_W = 35;
  localparam int POS_Y_W = 33;

  localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_TURNS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Z = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_GAINS = 3'd6;

  localparam logic [47:0] COLOR_GAINS_RESET = 48'h0100_0100_0100;

  localparam logic [1:0] REQ_VERTEX = 2'd0;
  localparam logic [1:0] REQ_INDEX = 2'd1;
  localparam logic [1:0] REQ_BEGIN = 2'd2;
  localparam logic [1:0] REQ_BOUNDS = 2'd3;

  localparam logic [1:0] RES_VERTEX = 2'd0;
  localparam logic [1:0] RES_INDEX = 2'd1;
  localparam logic [1:0] RES_BOUNDS = 2'd2;

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_pos_z;
    logic signed [15:0] in_norm_x;
    logic signed [15:0] in_norm_z;
    logic [15:0]        in_red;
    logic [15:0]        in_green;
    logic [15:0]        in_blue;
    logic [31:0]        in_index;
  } vqt_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_norm_x;
    logic signed [15:0] out_norm_z;
    logic [15:0]        out_red;
    logic [15:0]        out_green;
    logic [15:0]        out_blue;
    logic [31:0]        out_index;
    logic               last_of_run;
  } vqt_out_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [POS_SUM_W-1:0] sum_x;
    logic signed [POS_Y_W-1:0]   sum_y;
    logic signed [POS_SUM_W-1:0] sum_z;
    logic signed [15:0]          norm_x;
    logic signed [15:0]          norm_z;
    logic [31:0]                 prod_r;
    logic [31:0]                 prod_g;
    logic [31:0]                 prod_b;
    logic [31:0]                 index;
  } vqt_work_t;

  typedef enum logic {
    PH_HEAD,
    PH_MAX
  } vqt_phase_t;

endpackage
`default_nettype wire

FILE: rtl/vqt_stream_if.sv
// valid/ready stream channel carrying one word of a given payload type
`timescale 1ns / 1ps
`default_nettype none
interface vqt_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/vqt_front.sv
// front: config registers, request decode, vertex math, count and mesh base
`timescale 1ns / 1ps
`default_nettype none
module vqt_front import vqt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  vqt_stream_if.sink             item,
  output logic                   push,
  output vqt_work_t              push_word,
  input  logic                   q_full
);

  logic [1:0]         quarter_turns;
  logic signed [31:0] pivot_x;
  logic signed [31:0] pivot_z;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [47:0]        color_gains;

  logic [31:0] vertex_count;
  logic [31:0] mesh_base;

  logic      front_valid;
  vqt_work_t front_word;
  vqt_work_t work_next;
  logic      accept;

  logic signed [POS_SUM_W-1:0] px, pz, ox, oz, vx, vz, lx, lz;

  function automatic logic signed [POS_SUM_W-1:0] sext_pos(input logic signed [31:0] v);
    sext_pos = {{(POS_SUM_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    neg_sat = (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_turns <= 2'd0;
      pivot_x <= '0;
      pivot_z <= '0;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      color_gains <= COLOR_GAINS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUARTER_TURNS: quarter_turns <= cfg_data[1:0];
        REG_PIVOT_X:       pivot_x <= cfg_data[31:0];
        REG_PIVOT_Z:       pivot_z <= cfg_data[31:0];
        REG_OFFSET_X:      offset_x <= cfg_data[31:0];
        REG_OFFSET_Y:      offset_y <= cfg_data[31:0];
        REG_OFFSET_Z:      offset_z <= cfg_data[31:0];
        REG_COLOR_GAINS:   color_gains <= cfg_data[47:0];
        default: begin
        end
      endcase
    end
  end

  assign push = front_valid && !q_full;
  assign item.ready = !front_valid || push;
  assign accept = item.valid && item.ready;
  assign push_word = front_word;

  always_comb begin
    px = sext_pos(pivot_x);
    pz = sext_pos(pivot_z);
    ox = sext_pos(offset_x);
    oz = sext_pos(offset_z);
    vx = sext_pos(item.data.in_pos_x);
    vz = sext_pos(item.data.in_pos_z);
    lx = vx - px;
    lz = vz - pz;

    work_next = '0;
    work_next.kind = item.data.req_type;
    work_next.sum_y = {item.data.in_pos_y[31], item.data.in_pos_y}
                    + {offset_y[31], offset_y};
    unique case (quarter_turns)
      2'd0: begin
        work_next.sum_x = vx + ox;
        work_next.sum_z = vz + oz;
        work_next.norm_x = item.data.in_norm_x;
        work_next.norm_z = item.data.in_norm_z;
      end
      2'd1: begin
        work_next.sum_x = px + lz + ox;
        work_next.sum_z = pz - lx + oz;
        work_next.norm_x = item.data.in_norm_z;
        work_next.norm_z = neg_sat(item.data.in_norm_x);
      end
      2'd2: begin
        work_next.sum_x = px - lx + ox;
        work_next.sum_z = pz - lz + oz;
        work_next.norm_x = neg_sat(item.data.in_norm_x);
        work_next.norm_z = neg_sat(item.data.in_norm_z);
      end
      default: begin
        work_next.sum_x = px - lz + ox;
        work_next.sum_z = pz + lx + oz;
        work_next.norm_x = neg_sat(item.data.in_norm_z);
        work_next.norm_z = item.data.in_norm_x;
      end
    endcase
    work_next.prod_r = {16'd0, item.data.in_red} * {16'd0, color_gains[15:0]};
    work_next.prod_g = {16'd0, item.data.in_green} * {16'd0, color_gains[31:16]};
    work_next.prod_b = {16'd0, item.data.in_blue} * {16'd0, color_gains[47:32]};
    work_next.index = (item.data.req_type == REQ_INDEX)
                    ? mesh_base + item.data.in_index : vertex_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      mesh_base <= '0;
    end else if (accept) begin
      if (item.data.req_type == REQ_VERTEX) begin
        vertex_count <= vertex_count + 32'd1;
      end
      if (item.data.req_type == REQ_BEGIN) begin
        mesh_base <= vertex_count;
      end
    end
  end

  // begin-mesh words only move the base and never reach the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept && item.data.req_type != REQ_BEGIN) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_word <= work_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/vqt_queue.sv
// short queue of decoded words between front and back
`timescale 1ns / 1ps
`default_nettype none
module vqt_queue import vqt_pkg::*; #(
  parameter int DEPTH = VQT_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vqt_work_t push_word,
  output logic      full,
  output logic      q_valid,
  output vqt_work_t head,
  input  logic      pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vqt_work_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "vertex_quarter_turn_transform_core_assert.svh"
  `VQT_ASSERT_IMP(a_no_overflow, full, !push)
  `VQT_ASSERT_IMP(a_no_underflow, pop, q_valid)

endmodule
`default_nettype wire

FILE: rtl/vqt_back.sv
// back: saturation, scene bounds, bounds query expansion, output register
`timescale 1ns / 1ps
`default_nettype none
module vqt_back import vqt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  vqt_work_t head,
  output logic      pop,
  vqt_stream_if.source result
);

  vqt_phase_t phase;
  vqt_phase_t phase_next;
  logic       out_load;
  logic       load_word;
  logic       out_valid;
  vqt_out_t   out_word;
  vqt_out_t   word_next;

  logic signed [31:0] bound_min [3];
  logic signed [31:0] bound_max [3];
  logic signed [31:0] pos_sat [3];

  function automatic logic signed [31:0] sat_x(input logic signed [POS_SUM_W-1:0] v);
    if (v[POS_SUM_W-1:31] == '0 || v[POS_SUM_W-1:31] == '1) begin
      sat_x = v[31:0];
    end else begin
      sat_x = v[POS_SUM_W-1] ? POS_MIN : POS_MAX;
    end
  endfunction

  function automatic logic signed [31:0] sat_y(input logic signed [POS_Y_W-1:0] v);
    if (v[POS_Y_W-1] == v[31]) begin
      sat_y = v[31:0];
    end else begin
      sat_y = v[POS_Y_W-1] ? POS_MIN : POS_MAX;
    end
  endfunction

  function automatic logic [15:0] sat_col(input logic [31:0] p);
    sat_col = (p[31:24] != 8'd0) ? 16'hFFFF : p[23:8];
  endfunction

  assign pos_sat[0] = sat_x(head.sum_x);
  assign pos_sat[1] = sat_y(head.sum_y);
  assign pos_sat[2] = sat_x(head.sum_z);

  assign out_load = !out_valid || result.ready;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HEAD: begin
        if (q_valid && out_load && head.kind == REQ_BOUNDS) begin
          phase_next = PH_MAX;
        end
      end
      PH_MAX: begin
        if (out_load) begin
          phase_next = PH_HEAD;
        end
      end
      default: phase_next = PH_HEAD;
    endcase
  end

  always_comb begin
    load_word = q_valid && out_load;
    pop = load_word && (phase == PH_MAX || head.kind != REQ_BOUNDS);
  end

  always_comb begin
    word_next = '0;
    word_next.last_of_run = 1'b1;
    unique case (head.kind)
      REQ_VERTEX: begin
        word_next.result_kind = RES_VERTEX;
        word_next.out_pos_x = pos_sat[0];
        word_next.out_pos_y = pos_sat[1];
        word_next.out_pos_z = pos_sat[2];
        word_next.out_norm_x = head.norm_x;
        word_next.out_norm_z = head.norm_z;
        word_next.out_red = sat_col(head.prod_r);
        word_next.out_green = sat_col(head.prod_g);
        word_next.out_blue = sat_col(head.prod_b);
        word_next.out_index = head.index;
      end
      REQ_INDEX: begin
        word_next.result_kind = RES_INDEX;
        word_next.out_index = head.index;
      end
      default: begin
        word_next.result_kind = RES_BOUNDS;
        if (phase == PH_MAX) begin
          word_next.out_pos_x = bound_max[0];
          word_next.out_pos_y = bound_max[1];
          word_next.out_pos_z = bound_max[2];
        end else begin
          word_next.out_pos_x = bound_min[0];
          word_next.out_pos_y = bound_min[1];
          word_next.out_pos_z = bound_min[2];
          word_next.last_of_run = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (out_load) begin
        out_valid <= load_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_word) begin
      out_word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        bound_min[a] <= POS_MAX;
        bound_max[a] <= POS_MIN;
      end
    end else if (pop && head.kind == REQ_VERTEX) begin
      for (int a = 0; a < 3; a++) begin
        if (pos_sat[a] < bound_min[a]) begin
          bound_min[a] <= pos_sat[a];
        end
        if (pos_sat[a] > bound_max[a]) begin
          bound_max[a] <= pos_sat[a];
        end
      end
    end
  end

  assign result.valid = out_valid;
  assign result.data = out_word;

`include "vertex_quarter_turn_transform_core_assert.svh"
  `VQT_ASSERT_IMP(a_max_phase_on_query, phase == PH_MAX, q_valid && head.kind == REQ_BOUNDS)
  `VQT_ASSERT_IMP(a_only_min_not_last, out_valid && !out_word.last_of_run, out_word.result_kind == RES_BOUNDS)

endmodule
`default_nettype wire

FILE: rtl/vertex_quarter_turn_transform_core.sv
// top level of the vertex quarter-turn transform core
//
// item channel (sink): one word per request; vertex, index, begin mesh or
// bounds query, selected by req_type. result channel (source): vertex and
// index requests give one word, a bounds query gives two (min corner, then
// max corner with last_of_run set), begin mesh gives none.
// configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// write only while no request is in flight.
// throughput: one request per cycle while the result side keeps up; a bounds
// query holds the back end as the output register sends one word per cycle.
// a taken request goes through the front register, the queue and the output
// register on its way to the result channel.
// a stalled result side fills the output register, then the queue of
// QUEUE_DEPTH words, then the front register, after which item.ready drops.
// reset (rst, synchronous): registers return to defaults, vertex count and
// mesh base clear, bounds go to their extremes, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module vertex_quarter_turn_transform_core import vqt_pkg::*; #(
  parameter int QUEUE_DEPTH = VQT_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  vqt_stream_if.sink             item,
  vqt_stream_if.source           result
);

  logic      push;
  vqt_work_t push_word;
  logic      q_full;
  logic      q_valid;
  vqt_work_t head;
  logic      pop;

  vqt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .push      (push),
    .push_word (push_word),
    .q_full    (q_full)
  );

  vqt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop)
  );

  vqt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

FILE: sim/vertex_quarter_turn_transform_core_tb.sv
// testbench: streams vertex, index, mesh and bounds requests and checks each result word
`timescale 1ns / 1ps
module vertex_quarter_turn_transform_core_tb import vqt_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 90;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vqt_stream_if #(.payload_t(vqt_in_t)) item ();
  vqt_stream_if #(.payload_t(vqt_out_t)) result ();

  vertex_quarter_turn_transform_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item),
    .result(result)
  );

  // register mirror
  logic [1:0] cur_turns;
  logic signed [31:0] cur_pivot_x, cur_pivot_z;
  logic signed [31:0] cur_offset_x, cur_offset_y, cur_offset_z;
  logic [47:0] cur_gains;

  // scene state
  logic [31:0] vertex_total;
  logic [31:0] mesh_start;
  logic signed [31:0] low_corner [3];
  logic signed [31:0] high_corner [3];

  vqt_in_t scene_requests [$];
  vqt_out_t due_words [$];

  int pushed_count, taken_count;
  int tx_idle_pct, rx_idle_pct;
  int error_count, words_seen, cycle_count;
  int vertices_sent, indices_sent, meshes_sent, queries_sent, setting_count;
  bit hold_armed, hold_taken;
  int hold_left;

  always #10 clk = ~clk;

  function automatic logic signed [31:0] sat_pos(input longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat_norm(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] scale_channel(input logic [15:0] ch, input logic [15:0] gain);
    longint p;
    p = (longint'(ch) * longint'(gain)) >>> 8;
    return (p > 65535) ? 16'hFFFF : p[15:0];
  endfunction

  task automatic transform_request(input vqt_in_t req);
    longint c, s, px, pz, lx, lz, nx, nz;
    longint pos [3];
    logic signed [31:0] sp [3];
    vqt_out_t w;
    w = '0;
    case (req.req_type)
      REQ_VERTEX: begin
        case (cur_turns)
          2'd0: begin c = 1; s = 0; end
          2'd1: begin c = 0; s = 1; end
          2'd2: begin c = -1; s = 0; end
          default: begin c = 0; s = -1; end
        endcase
        px = longint'($signed(cur_pivot_x));
        pz = longint'($signed(cur_pivot_z));
        lx = longint'($signed(req.in_pos_x)) - px;
        lz = longint'($signed(req.in_pos_z)) - pz;
        pos[0] = px + lx * c + lz * s + longint'($signed(cur_offset_x));
        pos[1] = longint'($signed(req.in_pos_y)) + longint'($signed(cur_offset_y));
        pos[2] = pz - lx * s + lz * c + longint'($signed(cur_offset_z));
        for (int a = 0; a < 3; a++) begin
          sp[a] = sat_pos(pos[a]);
          if (sp[a] < low_corner[a]) low_corner[a] = sp[a];
          if (sp[a] > high_corner[a]) high_corner[a] = sp[a];
        end
        nx = longint'($signed(req.in_norm_x));
        nz = longint'($signed(req.in_norm_z));
        w.result_kind = RES_VERTEX;
        w.out_pos_x = sp[0];
        w.out_pos_y = sp[1];
        w.out_pos_z = sp[2];
        w.out_norm_x = sat_norm(nx * c + nz * s);
        w.out_norm_z = sat_norm(-nx * s + nz * c);
        w.out_red = scale_channel(req.in_red, cur_gains[15:0]);
        w.out_green = scale_channel(req.in_green, cur_gains[31:16]);
        w.out_blue = scale_channel(req.in_blue, cur_gains[47:32]);
        w.out_index = vertex_total;
        w.last_of_run = 1'b1;
        vertex_total = vertex_total + 32'd1;
        due_words.insert(due_words.size(), w);
        vertices_sent++;
      end
      REQ_INDEX: begin
        w.result_kind = RES_INDEX;
        w.out_index = mesh_start + req.in_index;
        w.last_of_run = 1'b1;
        due_words.insert(due_words.size(), w);
        indices_sent++;
      end
      REQ_BEGIN: begin
        mesh_start = vertex_total;
        meshes_sent++;
      end
      default: begin
        w.result_kind = RES_BOUNDS;
        w.out_pos_x = low_corner[0];
        w.out_pos_y = low_corner[1];
        w.out_pos_z = low_corner[2];
        due_words.insert(due_words.size(), w);
        w.out_pos_x = high_corner[0];
        w.out_pos_y = high_corner[1];
        w.out_pos_z = high_corner[2];
        w.last_of_run = 1'b1;
        due_words.insert(due_words.size(), w);
        queries_sent++;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at word %0d: got %h, want %h", what, words_seen, got, want);
    error_count++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
      item.data <= '0;
    end else begin
      if (item.valid && item.ready) begin
        transform_request(item.data);
        taken_count++;
      end
      if (!item.valid || item.ready) begin
        if (scene_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          item.valid <= 1'b1;
          item.data <= scene_requests.pop_front();
        end else begin
          item.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_armed && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : check_words
    vqt_out_t got, want;
    if (!rst && result.valid && result.ready) begin
      got = result.data;
      words_seen++;
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word", {30'd0, got.result_kind}, 32'd0);
      end else begin
        want = due_words.pop_front();
        if (got.result_kind !== want.result_kind)
          report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
        if (got.out_pos_x !== want.out_pos_x)
          report_mismatch("out_pos_x", got.out_pos_x, want.out_pos_x);
        if (got.out_pos_y !== want.out_pos_y)
          report_mismatch("out_pos_y", got.out_pos_y, want.out_pos_y);
        if (got.out_pos_z !== want.out_pos_z)
          report_mismatch("out_pos_z", got.out_pos_z, want.out_pos_z);
        if (got.out_norm_x !== want.out_norm_x)
          report_mismatch("out_norm_x", 32'(got.out_norm_x), 32'(want.out_norm_x));
        if (got.out_norm_z !== want.out_norm_z)
          report_mismatch("out_norm_z", 32'(got.out_norm_z), 32'(want.out_norm_z));
        if (got.out_red !== want.out_red)
          report_mismatch("out_red", 32'(got.out_red), 32'(want.out_red));
        if (got.out_green !== want.out_green)
          report_mismatch("out_green", 32'(got.out_green), 32'(want.out_green));
        if (got.out_blue !== want.out_blue)
          report_mismatch("out_blue", 32'(got.out_blue), 32'(want.out_blue));
        if (got.out_index !== want.out_index)
          report_mismatch("out_index", got.out_index, want.out_index);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, due_words.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_QUARTER_TURNS: cur_turns = val[1:0];
      REG_PIVOT_X: cur_pivot_x = val[31:0];
      REG_PIVOT_Z: cur_pivot_z = val[31:0];
      REG_OFFSET_X: cur_offset_x = val[31:0];
      REG_OFFSET_Y: cur_offset_y = val[31:0];
      REG_OFFSET_Z: cur_offset_z = val[31:0];
      REG_COLOR_GAINS: cur_gains = val[47:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [1:0] t, input logic [31:0] px, input logic [31:0] pz,
                              input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [47:0] g);
    write_reg(REG_QUARTER_TURNS, {46'd0, t});
    write_reg(REG_PIVOT_X, {16'd0, px});
    write_reg(REG_PIVOT_Z, {16'd0, pz});
    write_reg(REG_OFFSET_X, {16'd0, ox});
    write_reg(REG_OFFSET_Y, {16'd0, oy});
    write_reg(REG_OFFSET_Z, {16'd0, oz});
    write_reg(REG_COLOR_GAINS, g);
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic queue_request(input vqt_in_t r);
    scene_requests.insert(scene_requests.size(), r);
    pushed_count++;
  endtask

  task automatic wait_idle();
    while (taken_count != pushed_count || due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic vqt_in_t make_vertex(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] z, input logic [15:0] nx,
                                          input logic [15:0] nz, input logic [15:0] r,
                                          input logic [15:0] g, input logic [15:0] b);
    vqt_in_t v;
    v = '0;
    v.req_type = REQ_VERTEX;
    v.in_pos_x = x;
    v.in_pos_y = y;
    v.in_pos_z = z;
    v.in_norm_x = nx;
    v.in_norm_z = nz;
    v.in_red = r;
    v.in_green = g;
    v.in_blue = b;
    return v;
  endfunction

  function automatic vqt_in_t make_plain(input logic [1:0] kind, input logic [31:0] idx);
    vqt_in_t v;
    v = '0;
    v.req_type = kind;
    v.in_index = idx;
    return v;
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(7))
      0: return POS_MAX;
      1: return POS_MIN;
      2, 3: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_norm();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000;
      3: return 16'hC000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_colour();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_gains();
    logic [47:0] g;
    case ($urandom_range(3))
      0: g = 48'({$urandom, $urandom});
      1: g = COLOR_GAINS_RESET;
      2: g = {16'($urandom_range(16'h300)), 16'($urandom_range(16'h300)),
              16'($urandom_range(16'h300))};
      default: g = $urandom_range(1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] pick_offset();
    return $urandom_range(1) ? 32'($urandom_range(2000) - 1000) : pick_pos();
  endfunction

  function automatic vqt_in_t make_noise();
    vqt_in_t v;
    v = make_vertex($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
    v.req_type = 2'($urandom_range(3));
    v.in_index = $urandom;
    return v;
  endfunction

  initial begin
    int made, n_vert, n_idx;
    logic [31:0] ex_a, ex_b;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_QUARTER_TURNS;
    cfg_data = '0;
    item.valid = 1'b0;
    item.data = '0;
    result.ready = 1'b0;
    cur_turns = 2'd0;
    cur_pivot_x = '0;
    cur_pivot_z = '0;
    cur_offset_x = '0;
    cur_offset_y = '0;
    cur_offset_z = '0;
    cur_gains = COLOR_GAINS_RESET;
    vertex_total = '0;
    mesh_start = '0;
    for (int a = 0; a < 3; a++) begin
      low_corner[a] = POS_MAX;
      high_corner[a] = POS_MIN;
    end
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_armed = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset setting: empty bounds, unbased index, extreme vertices, mesh rebasing
    queue_request(make_plain(REQ_BOUNDS, 32'd0));
    queue_request(make_plain(REQ_INDEX, 32'hFFFF_FFFF));
    queue_request(make_vertex(POS_MAX, POS_MAX, POS_MAX, 16'h8000, 16'h7FFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_request(make_vertex(POS_MIN, POS_MIN, POS_MIN, 16'h7FFF, 16'h8000,
                              16'h0000, 16'h0000, 16'h0000));
    queue_request(make_plain(REQ_BEGIN, 32'd0));
    queue_request(make_plain(REQ_INDEX, 32'd0));
    queue_request(make_plain(REQ_INDEX, 32'hFFFF_FFFF));
    queue_request(make_vertex(32'd0, 32'd0, 32'd0, 16'd0, 16'd0,
                              16'h8000, 16'h8000, 16'h8000));
    queue_request(make_plain(REQ_BOUNDS, 32'd0));
    wait_idle();

    // each turn count with extreme pivots and with zero, extreme or mixed offsets and gains
    for (int t = 0; t < 4; t++) begin
      ex_a = t[0] ? POS_MIN : POS_MAX;
      ex_b = t[0] ? POS_MAX : POS_MIN;
      case (t)
        0: load_setting(2'd0, ex_a, ex_b, 32'd0, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
        1: load_setting(2'd1, ex_a, ex_b, POS_MAX, POS_MAX, POS_MAX, 48'h0);
        2: load_setting(2'd2, ex_a, ex_b, POS_MIN, POS_MIN, POS_MIN, 48'h0180_FFFF_0001);
        default: load_setting(2'd3, ex_a, ex_b, POS_MAX, POS_MIN, 32'h0001_0000,
                              48'h8000_0100_00FF);
      endcase
      queue_request(make_vertex(POS_MAX, POS_MAX, POS_MIN, 16'h8000, 16'h8000,
                                16'hFFFF, 16'h1234, 16'hFFFF));
      queue_request(make_vertex(POS_MIN, POS_MIN, POS_MAX, 16'h8000, 16'h7FFF,
                                16'h0001, 16'hFFFF, 16'h8000));
      queue_request(make_plain(REQ_BOUNDS, 32'd0));
      wait_idle();
    end

    // random phases: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 12;
        rx_idle_pct = 79;
      end else if (ph < 6) begin
        tx_idle_pct = 79;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      load_setting(2'($urandom_range(3)), pick_pos(), pick_pos(), pick_offset(),
                   pick_offset(), pick_offset(), pick_gains());
      if (ph == 6) hold_armed <= 1'b1;
      made = 0;
      while (made < 128) begin
        case ($urandom_range(9))
          0: begin
            queue_request(make_noise());
            made++;
          end
          1: begin
            queue_request(make_plain(REQ_BOUNDS, $urandom));
            made++;
          end
          default: begin
            n_vert = $urandom_range(1, 6);
            n_idx = $urandom_range(6);
            queue_request(make_plain(REQ_BEGIN, 32'd0));
            for (int k = 0; k < n_vert; k++)
              queue_request(make_vertex(pick_pos(), pick_pos(), pick_pos(), pick_norm(),
                                        pick_norm(), pick_colour(), pick_colour(),
                                        pick_colour()));
            for (int k = 0; k < n_idx; k++)
              queue_request(make_plain(REQ_INDEX, ($urandom_range(4) == 0) ? $urandom
                                       : 32'($urandom_range(n_vert - 1))));
            made += 1 + n_vert + n_idx;
          end
        endcase
      end
      wait_idle();
    end

    $display("covered %0d vertices, %0d indices, %0d mesh starts, %0d bounds queries",
             vertices_sent, indices_sent, meshes_sent, queries_sent);
    $display("under %0d register settings with %0d result words compared",
             setting_count, words_seen);
    if (error_count == 0 && due_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: vertex_quarter_turn_transform_core.f
+incdir+rtl
rtl/vqt_pkg.sv
rtl/vqt_stream_if.sv
rtl/vqt_front.sv
rtl/vqt_queue.sv
rtl/vqt_back.sv
rtl/vertex_quarter_turn_transform_core.sv
sim/vertex_quarter_turn_transform_core_tb.sv
